// ===== src/jep_pkg.sv =====
// Shared constants, types and hash functions of the jitter entropy pool.
`timescale 1ns / 1ps

package jep_pkg;

    // Samples folded into one hash before it is finalized and stored.
    localparam int SAMPLES_PER_WORD = 32;
    // Number of 32-bit words the pool holds.
    localparam int POOL_DEPTH       = 64;
    // Entries of the command queue between front and back.
    localparam int QUEUE_DEPTH      = 4;

    localparam int CNT_W   = (SAMPLES_PER_WORD > 1) ? $clog2(SAMPLES_PER_WORD) : 1;
    localparam int PTR_W   = $clog2(POOL_DEPTH);
    localparam int WC_W    = $clog2(POOL_DEPTH + 1);
    localparam int QPTR_W  = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int WORD_W  = 32;
    localparam int BYTE_W  = 8;
    localparam int WAVL_W  = 7;

    // Input kinds carried in s_tuser.
    localparam logic FUNC_SAMPLE  = 1'b0;
    localparam logic FUNC_REQUEST = 1'b1;

    // One command handed from the front to the back.
    typedef struct packed {
        logic              is_push;  // 1: store word (raw hash), 0: byte request
        logic [WORD_W-1:0] word;
    } jep_cmd_t;

    // One round of the one-at-a-time hash.
    function automatic logic [WORD_W-1:0] hash_fold(input logic [WORD_W-1:0] h,
                                                   input logic [BYTE_W-1:0] s);
        logic [WORD_W-1:0] t;
        t = h + {{(WORD_W-BYTE_W){1'b0}}, s};
        t = t + (t << 10);
        t = t ^ (t >> 6);
        return t;
    endfunction

    // Final avalanche of the one-at-a-time hash.
    function automatic logic [WORD_W-1:0] hash_final(input logic [WORD_W-1:0] h);
        logic [WORD_W-1:0] t;
        t = h + (h << 3);
        t = t ^ (t >> 11);
        t = t + (t << 15);
        return t;
    endfunction

    // Circular pool index step.
    function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(POOL_DEPTH - 1)) begin
            r = '0;
        end else begin
            r = p + 1'b1;
        end
        return r;
    endfunction

endpackage

// ===== src/jitter_entropy_pool.sv =====
// Top level of the jitter entropy pool: front end, command queue, pool back end.
`timescale 1ns / 1ps

// Order: a byte request accepted by the front end is written into the command queue; the
//   pool back end then moves it into the result register; it shows on m_* until taken.
// Throughput: one item per cycle, set by the back end retiring one queued command per cycle
//   on the single write / registered read port of the pool RAM; it holds while the queue
//   has room and, for a request, while the result register is empty or being taken.
// Reset (aresetn low, synchronous): hash, counters, pointers and queue clear at once;
//   the pool RAM is not cleared, and an entry is only read after it has been written.

module jitter_entropy_pool (
    input  logic        aclk,
    input  logic        aresetn,
    // Input items.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] sample
    input  logic        s_tuser,   // [0] func (0 = timer sample, 1 = byte request)
    // Result items, one per byte request.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] random_byte, [14:8] words_available, [15] zero
    output logic        m_tuser    // [0] byte_valid
);

    // The front end folds each accepted sample into the running hash. Every
    // request, and the sample that closes a batch, becomes a command in the
    // queue; the closing sample carries the unfinalized hash word.
    logic              fq_valid;
    logic              fq_ready;
    jep_pkg::jep_cmd_t fq_data;

    // The back end takes one command per cycle, a request only while the result
    // register is free or being taken: a push finalizes the word and writes it
    // into the pool, a request hands out the next byte and pops a word from the
    // pool when the held word is used up. The result register decouples it from
    // the output, so the queue keeps filling while a result waits to be taken.
    logic              qb_valid;
    logic              qb_ready;
    jep_pkg::jep_cmd_t qb_data;

    jep_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd_valid (fq_valid),
        .cmd_ready (fq_ready),
        .cmd_data  (fq_data)
    );

    jep_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_data   (fq_data),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_data  (qb_data)
    );

    jep_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (qb_valid),
        .cmd_ready (qb_ready),
        .cmd_data  (qb_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

// ===== src/jep_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
`timescale 1ns / 1ps

module jep_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                     aclk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic                                     re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/jep_front.sv =====
// Front end: accepts items, folds samples into the hash, queues commands.
`timescale 1ns / 1ps

module jep_front (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [7:0]               s_tdata,
    input  logic                     s_tuser,
    output logic                     cmd_valid,
    input  logic                     cmd_ready,
    output jep_pkg::jep_cmd_t        cmd_data
);

    logic [jep_pkg::WORD_W-1:0] hash_reg;
    logic [jep_pkg::WORD_W-1:0] hash_next;
    logic [jep_pkg::CNT_W-1:0]  count_reg;
    logic [jep_pkg::CNT_W-1:0]  count_next;
    logic [jep_pkg::WORD_W-1:0] folded;
    logic                       accept;
    logic                       batch_end;
    logic                       is_sample;

    assign s_tready  = cmd_ready;
    assign accept    = s_tvalid && s_tready;
    assign is_sample = (s_tuser == jep_pkg::FUNC_SAMPLE);
    assign folded    = jep_pkg::hash_fold(hash_reg, s_tdata);
    assign batch_end = (count_reg == jep_pkg::CNT_W'(jep_pkg::SAMPLES_PER_WORD - 1));

    // Requests always go to the back; samples only at the end of a batch.
    assign cmd_valid        = accept && (!is_sample || batch_end);
    assign cmd_data.is_push = is_sample;
    assign cmd_data.word    = folded;

    always_comb begin
        hash_next  = hash_reg;
        count_next = count_reg;
        if (accept && is_sample) begin
            if (batch_end) begin
                hash_next  = '0;
                count_next = '0;
            end else begin
                hash_next  = folded;
                count_next = count_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hash_reg  <= '0;
            count_reg <= '0;
        end else begin
            hash_reg  <= hash_next;
            count_reg <= count_next;
        end
    end

endmodule

// ===== src/jep_queue.sv =====
// Short command queue between the front end and the pool back end.
`timescale 1ns / 1ps

module jep_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  jep_pkg::jep_cmd_t in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output jep_pkg::jep_cmd_t out_data
);

    jep_pkg::jep_cmd_t           entry_reg [jep_pkg::QUEUE_DEPTH];
    logic [jep_pkg::QPTR_W-1:0]  wr_reg;
    logic [jep_pkg::QPTR_W-1:0]  wr_next;
    logic [jep_pkg::QPTR_W-1:0]  rd_reg;
    logic [jep_pkg::QPTR_W-1:0]  rd_next;
    logic [jep_pkg::QCNT_W-1:0]  cnt_reg;
    logic [jep_pkg::QCNT_W-1:0]  cnt_next;
    logic                        do_push;
    logic                        do_pop;

    assign in_ready  = (cnt_reg != jep_pkg::QCNT_W'(jep_pkg::QUEUE_DEPTH));
    assign out_valid = (cnt_reg != '0);
    assign out_data  = entry_reg[rd_reg];
    assign do_push   = in_valid && in_ready;
    assign do_pop    = out_valid && out_ready;

    always_comb begin
        wr_next  = do_push ? wr_reg + 1'b1 : wr_reg;
        rd_next  = do_pop ? rd_reg + 1'b1 : rd_reg;
        cnt_next = cnt_reg;
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_reg] <= in_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= jep_pkg::QCNT_W'(jep_pkg::QUEUE_DEPTH))
        else $error("command queue count out of range");

    a_empty_ptrs: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == '0) |-> (wr_reg == rd_reg))
        else $error("empty command queue with unequal pointers");

    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == jep_pkg::QCNT_W'(jep_pkg::QUEUE_DEPTH)) |=> (cnt_reg != '0))
        else $error("full command queue emptied in one cycle");

endmodule

// ===== src/jep_back.sv =====
// Back end: word pool, byte hand-out and the result register.
`timescale 1ns / 1ps

module jep_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cmd_valid,
    output logic              cmd_ready,
    input  jep_pkg::jep_cmd_t cmd_data,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [15:0]       m_tdata,
    output logic              m_tuser
);

    logic [jep_pkg::PTR_W-1:0]  wr_ptr_reg;
    logic [jep_pkg::PTR_W-1:0]  wr_ptr_next;
    logic [jep_pkg::PTR_W-1:0]  rd_ptr_reg;
    logic [jep_pkg::PTR_W-1:0]  rd_ptr_next;
    logic [jep_pkg::WC_W-1:0]   count_reg;
    logic [jep_pkg::WC_W-1:0]   count_next;
    logic [1:0]                 left_reg;
    logic [1:0]                 left_next;

    // Result stage: the byte itself is picked at the output from the RAM
    // read data or the held word.
    logic                       res_valid_reg;
    logic                       res_valid_next;
    logic                       res_pop_reg;
    logic                       res_pop_next;
    logic                       res_ok_reg;
    logic                       res_ok_next;
    logic [1:0]                 res_sel_reg;
    logic [1:0]                 res_sel_next;
    logic [jep_pkg::WAVL_W-1:0] res_words_reg;
    logic [jep_pkg::WAVL_W-1:0] res_words_next;
    logic [jep_pkg::WORD_W-1:0] held_word_reg;

    logic                       fire;
    logic                       out_take;
    logic                       pool_we;
    logic                       pool_re;
    logic [jep_pkg::WORD_W-1:0] pool_wdata;
    logic [jep_pkg::WORD_W-1:0] pool_rdata;
    logic [jep_pkg::WORD_W-1:0] word_sel;
    logic [jep_pkg::BYTE_W-1:0] byte_out;

    assign out_take  = res_valid_reg && m_tready;
    assign fire      = cmd_valid && (cmd_data.is_push || !res_valid_reg || m_tready);
    assign cmd_ready = fire;
    assign pool_we   = fire && cmd_data.is_push;
    assign pool_wdata = jep_pkg::hash_final(cmd_data.word);

    always_comb begin
        wr_ptr_next    = wr_ptr_reg;
        rd_ptr_next    = rd_ptr_reg;
        count_next     = count_reg;
        left_next      = left_reg;
        pool_re        = 1'b0;
        res_pop_next   = res_pop_reg;
        res_ok_next    = res_ok_reg;
        res_sel_next   = res_sel_reg;
        res_words_next = res_words_reg;
        res_valid_next = out_take ? 1'b0 : res_valid_reg;

        if (fire) begin
            if (cmd_data.is_push) begin
                wr_ptr_next = jep_pkg::next_ptr(wr_ptr_reg);
                if (count_reg == jep_pkg::WC_W'(jep_pkg::POOL_DEPTH)) begin
                    // Full: the oldest word is overwritten.
                    rd_ptr_next = jep_pkg::next_ptr(wr_ptr_reg);
                end else begin
                    count_next = count_reg + 1'b1;
                end
            end else begin
                res_valid_next = 1'b1;
                if (left_reg == 2'd0) begin
                    if (count_reg == '0) begin
                        // Empty pool: refused, the pool state does not change.
                        res_pop_next = 1'b0;
                        res_ok_next  = 1'b0;
                        res_sel_next = 2'd0;
                    end else begin
                        pool_re      = 1'b1;
                        rd_ptr_next  = jep_pkg::next_ptr(rd_ptr_reg);
                        count_next   = count_reg - 1'b1;
                        left_next    = 2'd3;
                        res_pop_next = 1'b1;
                        res_ok_next  = 1'b1;
                        res_sel_next = 2'd3;
                    end
                end else begin
                    left_next    = left_reg - 1'b1;
                    res_pop_next = 1'b0;
                    res_ok_next  = 1'b1;
                    res_sel_next = left_reg - 1'b1;
                end
                res_words_next = jep_pkg::WAVL_W'(count_next);
            end
        end
    end

    jep_ram #(
        .WIDTH(jep_pkg::WORD_W),
        .DEPTH(jep_pkg::POOL_DEPTH)
    ) u_pool (
        .aclk  (aclk),
        .we    (pool_we),
        .waddr (wr_ptr_reg),
        .wdata (pool_wdata),
        .re    (pool_re),
        .raddr (rd_ptr_reg),
        .rdata (pool_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            count_reg     <= '0;
            left_reg      <= '0;
            res_valid_reg <= 1'b0;
            held_word_reg <= '0;
        end else begin
            wr_ptr_reg    <= wr_ptr_next;
            rd_ptr_reg    <= rd_ptr_next;
            count_reg     <= count_next;
            left_reg      <= left_next;
            res_valid_reg <= res_valid_next;
            if (out_take && res_pop_reg) begin
                held_word_reg <= pool_rdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        res_pop_reg   <= res_pop_next;
        res_ok_reg    <= res_ok_next;
        res_sel_reg   <= res_sel_next;
        res_words_reg <= res_words_next;
    end

    assign word_sel = res_pop_reg ? pool_rdata : held_word_reg;
    assign byte_out = res_ok_reg ? word_sel[{res_sel_reg, 3'b000} +: jep_pkg::BYTE_W]
                                 : '0;

    assign m_tvalid = res_valid_reg;
    assign m_tdata  = {1'b0, res_words_reg, byte_out};
    assign m_tuser  = res_ok_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= jep_pkg::WC_W'(jep_pkg::POOL_DEPTH))
        else $error("pool word count out of range");

    a_ptrs_meet: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == '0 || count_reg == jep_pkg::WC_W'(jep_pkg::POOL_DEPTH))
        |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("pool pointers disagree with word count");

    a_refused_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid_reg && !res_ok_reg) |-> (res_words_reg == '0 && !res_pop_reg))
        else $error("refused byte while pool holds words");

    a_one_port_op: assert property (@(posedge aclk) disable iff (!aresetn)
        !(pool_we && pool_re))
        else $error("pool written and read by one command");

    a_pop_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid_reg && res_pop_reg && !m_tready) |=> $stable(pool_rdata))
        else $error("pool read data changed under a stalled result");

endmodule
